>>> hw/rtl/stream_distinct_value_filter_defines.svh
// assertion macros for the distinct value filter
// used by the top level; expects signals named clock and reset in scope
`ifndef STREAM_DISTINCT_VALUE_FILTER_DEFINES_SVH
`define STREAM_DISTINCT_VALUE_FILTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDVF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SDVF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sdvf_pkg.sv
// shared types and constants for the distinct value filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdvf_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int VALUE_W     = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_OUT_W = 7;

   typedef struct packed {
      logic                      start_req;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic                      stored;
      logic                      skipped_negative;
      logic [COUNT_OUT_W-1:0]    distinct_count;
      logic                      overflow;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } sdvf_state_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

endpackage

`default_nettype wire

>>> hw/rtl/sdvf_if.sv
// valid/ready channel interfaces for request and response transactions
// depends on sdvf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sdvf_req_if import sdvf_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdvf_rsp_if import sdvf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sdvf_ram.sv
// simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sdvf_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sdvf_ctrl.sv
// sequencer: accepts a transaction, scans the table one entry a cycle where a search is needed,
// then appends or flags and holds the result; depends on sdvf_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdvf_ctrl import sdvf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_payload,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output rsp_payload_type       res_payload,
   output ram_wr_type            ram_wr,
   output ram_rd_type            ram_rd,
   input  wire logic [VALUE_W-1:0] ram_rd_data
);

   sdvf_state_type            state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic                      cmp_last_ff, cmp_last_in;
   logic [VALUE_W-1:0]        val_ff, val_in;
   rsp_payload_type           res_ff, res_in;
   logic                      table_full;
   logic                      issue;
   logic                      hit;

   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign issue      = (scan_idx_ff < count_ff);
   assign hit        = cmp_vld_ff && (ram_rd_data == val_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         cmp_vld_ff  <= 1'b0;
         cmp_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         cmp_vld_ff  <= cmp_vld_in;
         cmp_last_ff <= cmp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      val_ff      <= val_in;
      res_ff      <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_last_in = 1'b0;
      val_in      = val_ff;
      res_in      = res_ff;
      ram_wr      = '0;
      ram_rd      = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in                  = req_payload.value;
               res_in.value_out        = req_payload.value;
               res_in.stored           = 1'b0;
               res_in.skipped_negative = 1'b0;
               res_in.overflow         = 1'b0;
               res_in.distinct_count   = COUNT_OUT_W'(count_ff);
               scan_idx_in             = '0;
               priority if (req_payload.start_req || (!req_payload.value[VALUE_W-1]
                                                      && count_ff == '0)) begin
                  // new set, or non-negative value into an empty table: the value goes to entry zero
                  ram_wr.en             = 1'b1;
                  ram_wr.addr           = '0;
                  ram_wr.data           = req_payload.value;
                  count_in              = CNT_W'(1);
                  res_in.stored         = 1'b1;
                  res_in.distinct_count = COUNT_OUT_W'(1);
                  state_in              = ST_EMIT;
               end else if (req_payload.value[VALUE_W-1]) begin
                  res_in.skipped_negative = 1'b1;
                  state_in                = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = scan_idx_ff[ADDR_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               cmp_vld_in  = 1'b1;
               cmp_last_in = (scan_idx_ff + CNT_W'(1) == count_ff);
            end
            priority if (hit) begin
               // duplicate: result fields already cleared on accept
               cmp_vld_in = 1'b0;
               state_in   = ST_EMIT;
            end else if (cmp_vld_ff && cmp_last_ff) begin
               if (table_full) begin
                  res_in.overflow = 1'b1;
               end else begin
                  ram_wr.en             = 1'b1;
                  ram_wr.addr           = count_ff[ADDR_W-1:0];
                  ram_wr.data           = val_ff;
                  count_in              = count_ff + CNT_W'(1);
                  res_in.stored         = 1'b1;
                  res_in.distinct_count = COUNT_OUT_W'(count_ff + CNT_W'(1));
               end
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_payload = res_ff;

endmodule

`default_nettype wire

>>> hw/rtl/stream_distinct_value_filter.sv
// channel   | dir | transaction payload
// ----------+-----+------------------------------------------------------------
// req_chan  | in  | start_req, value
// rsp_chan  | out | value_out, stored, skipped_negative, distinct_count, overflow
//
// one transaction at a time; a value needing a table search reads the stored
// entries in order (one table read a cycle through the single read port) and
// stops at the first duplicate; other values need no search.
// the table ram needs no clearing: only entries below the count are read.
// reset is synchronous and clears the count and control.
// an output register lets the next request be taken while a response stalls.
// depends on sdvf_pkg, sdvf_if, sdvf_ram, sdvf_ctrl and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "stream_distinct_value_filter_defines.svh"

module stream_distinct_value_filter import sdvf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   sdvf_req_if.sink   req_chan,
   sdvf_rsp_if.source rsp_chan
);

   ram_wr_type         ram_wr;
   ram_rd_type         ram_rd;
   logic [VALUE_W-1:0] ram_rd_data;
   logic               res_valid;
   logic               res_ready;
   rsp_payload_type    res_payload;
   logic               out_valid_ff, out_valid_in;
   rsp_payload_type    out_payload_ff, out_payload_in;
   logic [2:0]         out_flags;
   logic               out_stored;
   logic               out_counted;
   logic               rd_and_wr;

   sdvf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

   sdvf_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (VALUE_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rd_data)
   );

   // output register
   assign res_ready = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_payload_in = out_payload_ff;
      if (res_valid && res_ready) begin
         out_valid_in   = 1'b1;
         out_payload_in = res_payload;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_payload_ff <= out_payload_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_payload_ff;

   // outcome flags: stored, skipped, overflow
   assign out_flags   = {out_payload_ff.stored, out_payload_ff.skipped_negative,
                         out_payload_ff.overflow};
   assign out_stored  = out_valid_ff && out_payload_ff.stored;
   assign out_counted = (out_payload_ff.distinct_count != '0);
   assign rd_and_wr   = ram_wr.en && ram_rd.en;

   `SDVF_ASSERT_IMPL(a_outcome_exclusive, out_valid_ff, $onehot0(out_flags), "outcome flags clash")
   `SDVF_ASSERT_IMPL(a_stored_counts, out_stored, out_counted, "stored with zero count")
   `SDVF_ASSERT_IMPL(a_no_rw_collision, rd_and_wr, ram_wr.addr != ram_rd.addr, "table port clash")
   `SDVF_ASSERT_NEXT(a_result_lands, res_valid && res_ready, out_valid_ff, "result dropped")

endmodule

`default_nettype wire

>>> tb/sdvf_dedup_scoreboard.sv
// response checker for the distinct value filter: tracks the distinct table of the
// current set, predicts one response per request transaction and compares them in order
// depends on sdvf_pkg
`timescale 1ns / 1ps

module sdvf_dedup_scoreboard import sdvf_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   input  wire logic      req_ready,
   input  req_payload_type req_payload,
   input  wire logic      rsp_valid,
   input  wire logic      rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int unsigned    fail_count,
   output int unsigned    outstanding,
   output int unsigned    n_stored,
   output int unsigned    n_skipped,
   output int unsigned    n_dups,
   output int unsigned    n_drops
);

   logic [VALUE_W-1:0] kept_values [TABLE_DEPTH];
   int unsigned        kept_count;
   rsp_payload_type    pending_outcomes [$];

   // updates the table copy and returns what the block should report
   function automatic rsp_payload_type classify_value(input req_payload_type req);
      rsp_payload_type r;
      logic            hit;
      int unsigned     n;
      r = '0;
      r.value_out = req.value;
      if (req.start_req) begin
         kept_values[0] = req.value;
         kept_count = 1;
         r.stored = 1'b1;
      end else if (req.value[VALUE_W-1]) begin
         r.skipped_negative = 1'b1;
      end else begin
         hit = 1'b0;
         n = (kept_count > TABLE_DEPTH) ? TABLE_DEPTH : kept_count;
         for (int i = 0; i < n; i++)
            if (kept_values[i] == req.value) hit = 1'b1;
         if (!hit) begin
            if (n < TABLE_DEPTH) begin
               kept_values[n] = req.value;
               kept_count = n + 1;
               r.stored = 1'b1;
            end else begin
               r.overflow = 1'b1;
            end
         end
      end
      r.distinct_count = COUNT_OUT_W'(kept_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         kept_count = 0;
         pending_outcomes.delete();
      end else begin
         // a response never comes in the same cycle as its request, so check first
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("response transaction with nothing pending: value_out %0d",
                      rsp_payload.value_out);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_payload.value_out !== want.value_out) begin
                  $error("value_out mismatch: expected %0d, got %0d",
                         want.value_out, rsp_payload.value_out);
                  fail_count++;
               end
               if (rsp_payload.stored !== want.stored) begin
                  $error("stored mismatch: expected %0b, got %0b",
                         want.stored, rsp_payload.stored);
                  fail_count++;
               end
               if (rsp_payload.skipped_negative !== want.skipped_negative) begin
                  $error("skipped_negative mismatch: expected %0b, got %0b",
                         want.skipped_negative, rsp_payload.skipped_negative);
                  fail_count++;
               end
               if (rsp_payload.distinct_count !== want.distinct_count) begin
                  $error("distinct_count mismatch: expected %0d, got %0d",
                         want.distinct_count, rsp_payload.distinct_count);
                  fail_count++;
               end
               if (rsp_payload.overflow !== want.overflow) begin
                  $error("overflow mismatch: expected %0b, got %0b",
                         want.overflow, rsp_payload.overflow);
                  fail_count++;
               end
               if (want.stored) n_stored++;
               else if (want.skipped_negative) n_skipped++;
               else if (want.overflow) n_drops++;
               else n_dups++;
            end
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(classify_value(req_payload));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

>>> tb/tb_stream_distinct_value_filter.sv
// top of the distinct value filter testbench: clock, reset, request stimulus,
// response back-pressure and the verdict
// depends on sdvf_pkg, sdvf_if, the filter rtl and sdvf_dedup_scoreboard
`timescale 1ns / 1ps

module tb_stream_distinct_value_filter;
   import sdvf_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned ITEMS_PER_PHASE = 570;
   localparam int unsigned DRAIN_CYCLES    = 100;

   logic        clock;
   logic        reset;
   int unsigned cycles = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned items_sent = 0;
   int unsigned full_sets = 0;
   int unsigned fail_count, outstanding, n_stored, n_skipped, n_dups, n_drops;

   sdvf_req_if req_chan ();
   sdvf_rsp_if rsp_chan ();

   stream_distinct_value_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sdvf_dedup_scoreboard scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .n_stored    (n_stored),
      .n_skipped   (n_skipped),
      .n_dups      (n_dups),
      .n_drops     (n_drops)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** stream_distinct_value_filter: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   task automatic send_value(input logic first, input logic [VALUE_W-1:0] v);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid   <= 1'b0;
         req_chan.payload <= {1'($urandom), 32'($urandom)};
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{start_req: first, value: v};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // mostly non-negative values up to pool, so that with a small pool duplicates are common
   function automatic logic [VALUE_W-1:0] pick_value(input int unsigned pool);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'h8000_0000 | $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h8000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom_range(0, pool);
      endcase
   endfunction

   task automatic run_set(input int unsigned len, input int unsigned pool);
      send_value(1'b1, pick_value(pool));
      repeat (len) send_value(1'b0, pick_value(pool));
   endtask

   // fills all entries, then offers new values that must be dropped, then repeats them and one kept value
   task automatic fill_table();
      logic [VALUE_W-1:0] dropped [$];
      logic [VALUE_W-1:0] first_kept;
      logic [VALUE_W-1:0] v;
      send_value(1'b1, $urandom);
      for (int i = 1; i < TABLE_DEPTH + 6; i++) begin
         v = {1'b0, 31'($urandom)};
         if (i == 1) first_kept = v;
         if (i >= TABLE_DEPTH) dropped.push_back(v);
         send_value(1'b0, v);
         if ($urandom_range(0, 7) == 0) send_value(1'b0, 32'h8000_0000 | $urandom);
      end
      foreach (dropped[k]) send_value(1'b0, dropped[k]);
      send_value(1'b0, first_kept);
      full_sets++;
   endtask

   initial begin : stimulus
      int unsigned kind;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 13;
      rsp_idle_pct = 73;

      // before any start the table counts as empty
      send_value(1'b0, 32'hffff_fffb);
      send_value(1'b0, 32'd7);
      send_value(1'b0, 32'd7);
      // negative first value is kept
      send_value(1'b1, 32'h8000_0000);
      send_value(1'b0, 32'h0000_0000);
      send_value(1'b0, 32'h0000_0000);
      send_value(1'b0, 32'h7fff_ffff);
      send_value(1'b0, 32'hffff_ffff);
      send_value(1'b0, 32'h8000_0000);
      send_value(1'b0, 32'h5555_5555);
      send_value(1'b0, 32'h2aaa_aaaa);
      send_value(1'b0, 32'h7fff_ffff);
      send_value(1'b1, 32'hffff_ffff);
      send_value(1'b0, 32'hffff_ffff);
      send_value(1'b1, 32'h7fff_ffff);
      send_value(1'b0, 32'h7fff_ffff);
      send_value(1'b0, 32'h0000_0001);
      send_value(1'b1, 32'h0000_0000);
      send_value(1'b0, 32'h0000_0000);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 13; rsp_idle_pct = 73; end
            1: begin req_idle_pct = 73; rsp_idle_pct = 13; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         fill_table();
         while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) fill_table();
            else if (kind <= 2) run_set($urandom_range(1, 30), 32'h7fff_ffff);
            else run_set($urandom_range(1, 40), $urandom_range(3, 60));
         end
      end
      req_chan.valid <= 1'b0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d request transactions over three flow-control phases, %0d full-table sets",
               items_sent, full_sets);
      $display("responses: %0d stored, %0d negatives skipped, %0d duplicates, %0d full drops",
               n_stored, n_skipped, n_dups, n_drops);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** stream_distinct_value_filter: PASSED **");
      end else begin
         $display("** stream_distinct_value_filter: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sdvf_pkg.sv
hw/rtl/sdvf_if.sv
hw/rtl/sdvf_ram.sv
hw/rtl/sdvf_ctrl.sv
hw/rtl/stream_distinct_value_filter.sv
tb/sdvf_dedup_scoreboard.sv
tb/tb_stream_distinct_value_filter.sv
